[hw/rtl/sspr_pkg.sv]
// shared types and constants for the servo status packet receiver
package sspr_pkg;

    localparam int MAX_PARAMS = 16;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_LENGTH  = 8'd2;
    localparam logic [BYTE_W-1:0] MAX_LENGTH  = BYTE_W'(MAX_PARAMS + 2);

    // byte positions within a packet
    localparam logic [COUNT_W-1:0] POS_HDR0  = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_ID    = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_LEN   = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_ERR   = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] POS_PARAM = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] POS_LAST  = COUNT_W'(MAX_PARAMS + 5);

    typedef enum logic [1:0] {
        STATUS_BUSY   = 2'd0,
        STATUS_GOOD   = 2'd1,
        STATUS_CSUM   = 2'd2,
        STATUS_BADLEN = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  byte_index;
        logic [BYTE_W-1:0]   data_byte;
        logic [BYTE_W-1:0]   servo_id;
        logic [BYTE_W-1:0]   error_flags;
        logic [BYTE_W-1:0]   packet_length;
    } result_t;

endpackage

[hw/rtl/servo_status_packet_receiver.sv]
// servo status packet receiver: input register, framer and result register
// an accepted byte moves from the input register through the framer to the result register on m_valid
// throughput: one byte per cycle while results are taken, set by the single-pass framer between two registers
// a waiting result lets the input register hold one more byte, then s_ready drops
// reset (aresetn low, synchronous) empties both registers and returns to the header hunt
module servo_status_packet_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sspr_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [sspr_pkg::COUNT_W-1:0]  m_byte_index,
    output logic [sspr_pkg::BYTE_W-1:0]   m_data_byte,
    output logic [sspr_pkg::BYTE_W-1:0]   m_servo_id,
    output logic [sspr_pkg::BYTE_W-1:0]   m_error_flags,
    output logic [sspr_pkg::BYTE_W-1:0]   m_packet_length
);

    logic                        in_vld_reg, in_vld_next;
    logic [sspr_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_vld_reg, out_vld_next;
    sspr_pkg::result_t           out_result_reg;
    sspr_pkg::result_t           result;
    logic                        advance;

    // item moves from input register to result register
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    sspr_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_status        = out_result_reg.status;
    assign m_byte_index    = out_result_reg.byte_index;
    assign m_data_byte     = out_result_reg.data_byte;
    assign m_servo_id      = out_result_reg.servo_id;
    assign m_error_flags   = out_result_reg.error_flags;
    assign m_packet_length = out_result_reg.packet_length;

endmodule

[hw/rtl/sspr_framer.sv]
// packet framing state, running checksum and per-byte result
module sspr_framer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [sspr_pkg::BYTE_W-1:0] rx_byte,
    output sspr_pkg::result_t           result
);

    logic [sspr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [sspr_pkg::BYTE_W-1:0]  length_reg, length_next;
    logic [sspr_pkg::BYTE_W-1:0]  sum_reg, sum_next;
    logic [sspr_pkg::BYTE_W-1:0]  id_reg, id_next;
    logic [sspr_pkg::BYTE_W-1:0]  error_reg, error_next;
    sspr_pkg::status_t            status;
    logic [sspr_pkg::COUNT_W-1:0] index;
    logic [sspr_pkg::BYTE_W-1:0]  sum_add;
    logic                         at_checksum;

    assign sum_add     = sum_reg + rx_byte;
    assign at_checksum = {1'b0, 3'b000, count_reg} >= ({1'b0, length_reg} + 9'd3);

    always_comb begin
        count_next  = count_reg;
        length_next = length_reg;
        sum_next    = sum_reg;
        id_next     = id_reg;
        error_next  = error_reg;
        status      = sspr_pkg::STATUS_BUSY;
        index       = count_reg;

        if (count_reg < sspr_pkg::POS_ID) begin
            if (rx_byte == sspr_pkg::HEADER_BYTE) begin
                count_next = count_reg + 1'b1;
            end else begin
                count_next = sspr_pkg::POS_HDR0;
                index      = sspr_pkg::POS_HDR0;
            end
        end else if (count_reg == sspr_pkg::POS_ID) begin
            // a third 0xff is simply the id
            id_next     = rx_byte;
            sum_next    = rx_byte;
            length_next = '0;
            error_next  = '0;
            count_next  = sspr_pkg::POS_LEN;
        end else if (count_reg == sspr_pkg::POS_LEN) begin
            length_next = rx_byte;
            sum_next    = sum_add;
            if (rx_byte < sspr_pkg::MIN_LENGTH || rx_byte > sspr_pkg::MAX_LENGTH) begin
                status     = sspr_pkg::STATUS_BADLEN;
                count_next = sspr_pkg::POS_HDR0;
            end else begin
                count_next = sspr_pkg::POS_ERR;
            end
        end else if (count_reg == sspr_pkg::POS_ERR) begin
            error_next = rx_byte;
            sum_next   = sum_add;
            count_next = sspr_pkg::POS_PARAM;
        end else if (at_checksum) begin
            status     = (~sum_reg == rx_byte) ? sspr_pkg::STATUS_GOOD
                                                : sspr_pkg::STATUS_CSUM;
            count_next = sspr_pkg::POS_HDR0;
        end else begin
            sum_next   = sum_add;
            count_next = count_reg + 1'b1;
        end
    end

    assign result.status        = status;
    assign result.byte_index    = index;
    assign result.data_byte     = rx_byte;
    assign result.servo_id      = id_next;
    assign result.error_flags   = error_next;
    assign result.packet_length = length_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            length_reg <= '0;
            sum_reg    <= '0;
            id_reg     <= '0;
            error_reg  <= '0;
        end else if (step) begin
            count_reg  <= count_next;
            length_reg <= length_next;
            sum_reg    <= sum_next;
            id_reg     <= id_next;
            error_reg  <= error_next;
        end
    end

    // position never runs past the longest packet
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sspr_pkg::POS_LAST)
        else $error("byte position beyond longest packet");

    // parameter positions only follow an accepted length
    a_length_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= sspr_pkg::POS_PARAM |->
            (length_reg >= sspr_pkg::MIN_LENGTH && length_reg <= sspr_pkg::MAX_LENGTH))
        else $error("parameter position with invalid length");

    // any packet end returns to the header hunt
    a_end_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        step && status != sspr_pkg::STATUS_BUSY |=> count_reg == sspr_pkg::POS_HDR0)
        else $error("no resync after packet end");

endmodule

[tb/sv/servo_status_packet_receiver_test.sv]
// self-checking testbench for the servo status packet receiver
module servo_status_packet_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 1350;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 16;

    // tracks framing state and holds the results the block owes us
    class frame_scoreboard;
        logic [sspr_pkg::COUNT_W-1:0] pos;
        logic [sspr_pkg::BYTE_W-1:0]  len_q;
        logic [sspr_pkg::BYTE_W-1:0]  sum_q;
        logic [sspr_pkg::BYTE_W-1:0]  id_q;
        logic [sspr_pkg::BYTE_W-1:0]  err_q;
        sspr_pkg::result_t            pending[$];
        int                           mismatches;
        int                           checked;
        int                           n_good;
        int                           n_csum;
        int                           n_badlen;

        function new();
            pos = sspr_pkg::POS_HDR0;
            len_q = '0;
            sum_q = '0;
            id_q = '0;
            err_q = '0;
            mismatches = 0;
            checked = 0;
            n_good = 0;
            n_csum = 0;
            n_badlen = 0;
        endfunction

        function void note_byte(logic [sspr_pkg::BYTE_W-1:0] b);
            sspr_pkg::result_t r;
            r.status = sspr_pkg::STATUS_BUSY;
            r.byte_index = pos;
            r.data_byte = b;
            if (pos < sspr_pkg::POS_ID) begin
                if (b == sspr_pkg::HEADER_BYTE) begin
                    pos = pos + 1'b1;
                end else begin
                    // not a header, back to the hunt without rescanning
                    pos = sspr_pkg::POS_HDR0;
                    r.byte_index = sspr_pkg::POS_HDR0;
                end
            end else if (pos == sspr_pkg::POS_ID) begin
                id_q = b;
                sum_q = b;
                len_q = '0;
                err_q = '0;
                pos = sspr_pkg::POS_LEN;
            end else if (pos == sspr_pkg::POS_LEN) begin
                len_q = b;
                sum_q = sum_q + b;
                if (b < sspr_pkg::MIN_LENGTH || b > sspr_pkg::MAX_LENGTH) begin
                    r.status = sspr_pkg::STATUS_BADLEN;
                    pos = sspr_pkg::POS_HDR0;
                    n_badlen++;
                end else begin
                    pos = sspr_pkg::POS_ERR;
                end
            end else if (pos == sspr_pkg::POS_ERR) begin
                err_q = b;
                sum_q = sum_q + b;
                pos = sspr_pkg::POS_PARAM;
            end else if (int'(pos) >= int'(len_q) + 3) begin
                if ((~sum_q) == b) begin
                    r.status = sspr_pkg::STATUS_GOOD;
                    n_good++;
                end else begin
                    r.status = sspr_pkg::STATUS_CSUM;
                    n_csum++;
                end
                pos = sspr_pkg::POS_HDR0;
            end else begin
                sum_q = sum_q + b;
                pos = pos + 1'b1;
            end
            r.servo_id = id_q;
            r.error_flags = err_q;
            r.packet_length = len_q;
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("%0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_result(sspr_pkg::result_t got);
            sspr_pkg::result_t exp;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending, data_byte %0h", got.data_byte));
            end else begin
                exp = pending.pop_front();
                checked++;
                if (got.status != exp.status)
                    report($sformatf("status got %0d expected %0d (byte %0h)",
                        got.status, exp.status, exp.data_byte));
                if (got.byte_index != exp.byte_index)
                    report($sformatf("byte_index got %0d expected %0d",
                        got.byte_index, exp.byte_index));
                if (got.data_byte != exp.data_byte)
                    report($sformatf("data_byte got %0h expected %0h",
                        got.data_byte, exp.data_byte));
                if (got.servo_id != exp.servo_id)
                    report($sformatf("servo_id got %0h expected %0h",
                        got.servo_id, exp.servo_id));
                if (got.error_flags != exp.error_flags)
                    report($sformatf("error_flags got %0h expected %0h",
                        got.error_flags, exp.error_flags));
                if (got.packet_length != exp.packet_length)
                    report($sformatf("packet_length got %0h expected %0h",
                        got.packet_length, exp.packet_length));
            end
        endtask
    endclass

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [sspr_pkg::BYTE_W-1:0]  s_rx_byte = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_status;
    logic [sspr_pkg::COUNT_W-1:0] m_byte_index;
    logic [sspr_pkg::BYTE_W-1:0]  m_data_byte;
    logic [sspr_pkg::BYTE_W-1:0]  m_servo_id;
    logic [sspr_pkg::BYTE_W-1:0]  m_error_flags;
    logic [sspr_pkg::BYTE_W-1:0]  m_packet_length;

    frame_scoreboard   sb;
    int                bytes_sent = 0;
    int                stall_cycles = 0;
    sspr_pkg::result_t got;

    // no idling on either side for a stretch in the middle of the run
    wire calm = (bytes_sent >= 500) && (bytes_sent < 700);

    servo_status_packet_receiver u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_byte_index    (m_byte_index),
        .m_data_byte     (m_data_byte),
        .m_servo_id      (m_servo_id),
        .m_error_flags   (m_error_flags),
        .m_packet_length (m_packet_length)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                got.status = sspr_pkg::status_t'(m_status);
                got.byte_index = m_byte_index;
                got.data_byte = m_data_byte;
                got.servo_id = m_servo_id;
                got.error_flags = m_error_flags;
                got.packet_length = m_packet_length;
                sb.check_result(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("no progress for %0d cycles", STALL_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [sspr_pkg::BYTE_W-1:0] b);
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // header, id and length; the rest only when the length is legal
    task automatic send_frame(input logic [sspr_pkg::BYTE_W-1:0] id,
                              input logic [sspr_pkg::BYTE_W-1:0] len,
                              input logic [sspr_pkg::BYTE_W-1:0] err, input bit corrupt);
        logic [sspr_pkg::BYTE_W-1:0] sum;
        logic [sspr_pkg::BYTE_W-1:0] p;
        send_byte(sspr_pkg::HEADER_BYTE);
        send_byte(sspr_pkg::HEADER_BYTE);
        send_byte(id);
        send_byte(len);
        sum = id + len;
        if (len >= sspr_pkg::MIN_LENGTH && len <= sspr_pkg::MAX_LENGTH) begin
            send_byte(err);
            sum = sum + err;
            for (int i = 2; i < int'(len); i++) begin
                p = 8'($urandom_range(0, 255));
                send_byte(p);
                sum = sum + p;
            end
            if (corrupt)
                send_byte((~sum) ^ 8'($urandom_range(1, 255)));
            else
                send_byte(~sum);
        end
    endtask

    initial begin
        int pick;
        sb = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: hunt, dropped header, id of 0xff, lengths at the lower limit and past both limits
        send_byte(8'h00);
        send_byte(sspr_pkg::HEADER_BYTE);
        send_byte(8'h55);
        send_frame(8'hFF, 8'd1, 8'h00, 1'b0);
        send_frame(8'h07, 8'hFF, 8'h00, 1'b0);
        send_frame(8'h00, sspr_pkg::MIN_LENGTH, 8'h00, 1'b0);
        send_frame(8'h01, sspr_pkg::MAX_LENGTH + 1'b1, 8'h00, 1'b0);
        send_frame(8'hFE, sspr_pkg::MIN_LENGTH, 8'h80, 1'b1);

        while (bytes_sent < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(8'($urandom_range(0, 255)),
                           8'($urandom_range(sspr_pkg::MIN_LENGTH, sspr_pkg::MAX_LENGTH)),
                           8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end else if (pick < 80) begin
                send_frame(8'($urandom_range(0, 255)),
                           $urandom_range(0, 1) ?
                               8'($urandom_range(0, 1)) :
                               8'($urandom_range(sspr_pkg::MAX_LENGTH + 1, 255)),
                           8'h00, 1'b0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end else begin
                // header cut short by a stray byte
                send_byte(sspr_pkg::HEADER_BYTE);
                send_byte(8'($urandom_range(0, sspr_pkg::HEADER_BYTE - 1)));
            end
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));

        $display("%0d bytes sent, %0d results checked, %0d errors",
                 bytes_sent, sb.checked, sb.mismatches);
        $display("packets: %0d good, %0d checksum errors, %0d bad lengths",
                 sb.n_good, sb.n_csum, sb.n_badlen);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sspr_pkg.sv
hw/rtl/sspr_framer.sv
hw/rtl/servo_status_packet_receiver.sv
tb/sv/servo_status_packet_receiver_test.sv
